// File: hdl/weighted_graph_adjacency_matrix_macros.svh
// Assertion macros shared by the graph store RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef WEIGHTED_GRAPH_ADJACENCY_MATRIX_MACROS_SVH
`define WEIGHTED_GRAPH_ADJACENCY_MATRIX_MACROS_SVH

// same-cycle implication
`define WGAM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WGAM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/wgam_pkg.sv
// Types, constants and helpers for the weighted graph adjacency matrix.
// Used by the sequencer, output register and top level.
`default_nettype none

package wgam_pkg;

  localparam int VERTICES = 8;
  localparam int CELLS    = VERTICES * VERTICES;
  localparam int VTX_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int ENTRY_W  = WEIGHT_W + 1;
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W    = $clog2(VERTICES + 2);

  localparam logic OP_LIST   = 1'b0;
  localparam logic OP_MODIFY = 1'b1;

  typedef enum logic [1:0] {
    ST_NEIGHBOR = 2'd0,
    ST_NONE     = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WR2  = 2'd1,
    S_SCAN = 2'd2,
    S_FIN  = 2'd3
  } state_t;

  typedef struct packed {
    status_t                     status;
    logic [VTX_W-1:0]            neighbor;
    logic signed [WEIGHT_W-1:0]  weight;
    logic                        last;
  } res_t;

  function automatic logic name_ok(input logic [VTX_W-1:0] v);
    return (v != '0) && (v <= VTX_W'(VERTICES));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [VTX_W-1:0] r,
                                                  input logic [VTX_W-1:0] c);
    int idx;
    idx = (int'(r) - 1) * VERTICES + (int'(c) - 1);
    return ADDR_W'(idx);
  endfunction

endpackage

`default_nettype wire

// File: hdl/weighted_graph_adjacency_matrix.sv
// Channel    | Ports                                                 | Direction
// input      | in_valid, in_stall, in_operation, in_vertex_a,        | in (stall out)
//            | in_vertex_b, in_edge_weight                           |
// result     | out_valid, out_stall, out_status, out_neighbor,       | out (stall in)
//            | out_neighbor_weight, out_last                         |
// A query steps through accept, one edge memory read per column and a finish state.
// A modify does one write per direction through the single memory port.
// An invalid name gives one result.
// Reset clears the per-entry valid bits; no clearing pass.
// A stalled result holds the output register; a further hit pauses the row scan.
// Top level of the weighted graph adjacency matrix; depends on wgam_pkg,
// wgam_seq, wgam_obuf and wgam_ram.
`default_nettype none

module weighted_graph_adjacency_matrix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_operation,
  input  logic [wgam_pkg::VTX_W-1:0]            in_vertex_a,
  input  logic [wgam_pkg::VTX_W-1:0]            in_vertex_b,
  input  logic signed [wgam_pkg::WEIGHT_W-1:0]  in_edge_weight,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_status,
  output logic [wgam_pkg::VTX_W-1:0]            out_neighbor,
  output logic signed [wgam_pkg::WEIGHT_W-1:0]  out_neighbor_weight,
  output logic                                  out_last
);

  logic                             ram_we;
  logic                             ram_re;
  logic [wgam_pkg::ADDR_W-1:0]      ram_addr;
  logic [wgam_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [wgam_pkg::ENTRY_W-1:0]     ram_rdata;
  logic                             push;
  logic                             push_ready;
  wgam_pkg::res_t                   push_res;
  wgam_pkg::res_t                   out_res;

  wgam_ram #(
    .WIDTH (wgam_pkg::ENTRY_W),
    .DEPTH (wgam_pkg::CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  wgam_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_edge_weight (in_edge_weight),
    .ram_we         (ram_we),
    .ram_re         (ram_re),
    .ram_addr       (ram_addr),
    .ram_wdata      (ram_wdata),
    .ram_rdata      (ram_rdata),
    .push           (push),
    .push_res       (push_res),
    .push_ready     (push_ready)
  );

  wgam_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_res   (push_res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  assign out_status          = out_res.status;
  assign out_neighbor        = out_res.neighbor;
  assign out_neighbor_weight = out_res.weight;
  assign out_last            = out_res.last;

endmodule

`default_nettype wire

// File: hdl/wgam_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module wgam_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
  input  logic [WIDTH-1:0]                              wdata,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/wgam_obuf.sv
// Output register for result transfers.
// Depends on wgam_pkg.
`default_nettype none

module wgam_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wgam_pkg::res_t push_res,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output wgam_pkg::res_t out_res
);

  logic           out_valid_r;
  wgam_pkg::res_t out_res_r;

  assign push_ready = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= push_res;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wgam_seq.sv
// Sequencer: accepts items, writes edges, scans a matrix row, builds results.
// Depends on wgam_pkg, the RAM port of the top level and the assertion macros.
`default_nettype none
`include "weighted_graph_adjacency_matrix_macros.svh"

module wgam_seq (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     in_operation,
  input  logic [wgam_pkg::VTX_W-1:0]               in_vertex_a,
  input  logic [wgam_pkg::VTX_W-1:0]               in_vertex_b,
  input  logic signed [wgam_pkg::WEIGHT_W-1:0]     in_edge_weight,
  output logic                                     ram_we,
  output logic                                     ram_re,
  output logic [wgam_pkg::ADDR_W-1:0]              ram_addr,
  output logic [wgam_pkg::ENTRY_W-1:0]             ram_wdata,
  input  logic [wgam_pkg::ENTRY_W-1:0]             ram_rdata,
  output logic                                     push,
  output wgam_pkg::res_t                           push_res,
  input  logic                                     push_ready
);

  wgam_pkg::state_t                       state_r, state_nxt;
  logic [wgam_pkg::VTX_W-1:0]             a_r, a_nxt;
  logic [wgam_pkg::VTX_W-1:0]             b_r, b_nxt;
  logic signed [wgam_pkg::WEIGHT_W-1:0]   w_r, w_nxt;
  logic [wgam_pkg::CNT_W-1:0]             rd_col_r, rd_col_nxt;
  logic                                   chk_vld_r, chk_vld_nxt;
  logic [wgam_pkg::VTX_W-1:0]             chk_col_r, chk_col_nxt;
  logic                                   hold_vld_r, hold_vld_nxt;
  wgam_pkg::res_t                         hold_r, hold_nxt;
  logic [wgam_pkg::CELLS-1:0]             valid_r, valid_nxt;

  logic [wgam_pkg::ADDR_W-1:0]            chk_addr;
  logic                                   hit;
  logic                                   blocked;
  logic                                   issue;
  wgam_pkg::res_t                         bad_res;

  assign chk_addr = wgam_pkg::cell_addr(a_r, chk_col_r);
  assign hit      = chk_vld_r && valid_r[chk_addr] && ram_rdata[wgam_pkg::WEIGHT_W];
  assign in_stall = (state_r != wgam_pkg::S_IDLE);
  assign bad_res  = '{status: wgam_pkg::ST_INVALID, neighbor: '0, weight: '0, last: 1'b0};

  always_comb begin
    state_nxt    = state_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    w_nxt        = w_r;
    rd_col_nxt   = rd_col_r;
    chk_vld_nxt  = chk_vld_r;
    chk_col_nxt  = chk_col_r;
    hold_vld_nxt = hold_vld_r;
    hold_nxt     = hold_r;
    valid_nxt    = valid_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = '0;
    ram_wdata    = '0;
    push         = 1'b0;
    push_res     = hold_r;
    blocked      = 1'b0;
    issue        = 1'b0;
    case (state_r)
      wgam_pkg::S_IDLE: begin
        if (in_valid) begin
          a_nxt        = in_vertex_a;
          b_nxt        = in_vertex_b;
          w_nxt        = in_edge_weight;
          hold_vld_nxt = 1'b0;
          chk_vld_nxt  = 1'b0;
          if (in_operation == wgam_pkg::OP_MODIFY) begin
            if (wgam_pkg::name_ok(in_vertex_a) && wgam_pkg::name_ok(in_vertex_b)) begin
              ram_we              = 1'b1;
              ram_addr            = wgam_pkg::cell_addr(in_vertex_a, in_vertex_b);
              ram_wdata           = {in_edge_weight != '0, in_edge_weight};
              valid_nxt[ram_addr] = 1'b1;
              state_nxt           = wgam_pkg::S_WR2;
            end else begin
              hold_nxt     = bad_res;
              hold_vld_nxt = 1'b1;
              state_nxt    = wgam_pkg::S_FIN;
            end
          end else begin
            if (wgam_pkg::name_ok(in_vertex_a)) begin
              ram_re      = 1'b1;
              ram_addr    = wgam_pkg::cell_addr(in_vertex_a, wgam_pkg::VTX_W'(1));
              chk_vld_nxt = 1'b1;
              chk_col_nxt = wgam_pkg::VTX_W'(1);
              rd_col_nxt  = wgam_pkg::CNT_W'(2);
              state_nxt   = wgam_pkg::S_SCAN;
            end else begin
              hold_nxt     = bad_res;
              hold_vld_nxt = 1'b1;
              state_nxt    = wgam_pkg::S_FIN;
            end
          end
        end
      end
      wgam_pkg::S_WR2: begin
        ram_we              = 1'b1;
        ram_addr            = wgam_pkg::cell_addr(b_r, a_r);
        ram_wdata           = {w_r != '0, w_r};
        valid_nxt[ram_addr] = 1'b1;
        state_nxt           = wgam_pkg::S_IDLE;
      end
      wgam_pkg::S_SCAN: begin
        blocked = hit && hold_vld_r && !push_ready;
        if (!blocked) begin
          issue       = (rd_col_r <= wgam_pkg::CNT_W'(wgam_pkg::VERTICES));
          chk_vld_nxt = issue;
          if (issue) begin
            ram_re      = 1'b1;
            ram_addr    = wgam_pkg::cell_addr(a_r, wgam_pkg::VTX_W'(rd_col_r));
            rd_col_nxt  = rd_col_r + 1'b1;
            chk_col_nxt = wgam_pkg::VTX_W'(rd_col_r);
          end else begin
            state_nxt = wgam_pkg::S_FIN;
          end
          if (hit) begin
            push         = hold_vld_r;
            hold_nxt     = '{status: wgam_pkg::ST_NEIGHBOR, neighbor: chk_col_r,
                             weight: ram_rdata[wgam_pkg::WEIGHT_W-1:0], last: 1'b0};
            hold_vld_nxt = 1'b1;
          end
        end
      end
      wgam_pkg::S_FIN: begin
        if (hold_vld_r) begin
          push_res      = hold_r;
          push_res.last = 1'b1;
        end else begin
          push_res = '{status: wgam_pkg::ST_NONE, neighbor: '0, weight: '0, last: 1'b1};
        end
        if (push_ready) begin
          push      = 1'b1;
          state_nxt = wgam_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wgam_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wgam_pkg::S_IDLE;
      chk_vld_r  <= 1'b0;
      hold_vld_r <= 1'b0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      chk_vld_r  <= chk_vld_nxt;
      hold_vld_r <= hold_vld_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    w_r       <= w_nxt;
    rd_col_r  <= rd_col_nxt;
    chk_col_r <= chk_col_nxt;
    hold_r    <= hold_nxt;
  end

  `WGAM_ASSERT_IMP(a_push_state, clk, rst_n, push,
    (state_r == wgam_pkg::S_SCAN) || (state_r == wgam_pkg::S_FIN),
    "result pushed outside scan or finish")
  `WGAM_ASSERT_NXT(a_last_idle, clk, rst_n, push && push_res.last,
    state_r == wgam_pkg::S_IDLE, "no return to idle after last result")
  `WGAM_ASSERT_IMP(a_chk_scan, clk, rst_n, chk_vld_r,
    state_r == wgam_pkg::S_SCAN, "row entry pending outside scan")
  `WGAM_ASSERT_NXT(a_wr2_idle, clk, rst_n, state_r == wgam_pkg::S_WR2,
    (state_r == wgam_pkg::S_IDLE) && ($past(ram_we)), "second edge write missed")

endmodule

`default_nettype wire

// File: sim/tb_weighted_graph_adjacency_matrix.sv
// Testbench for weighted_graph_adjacency_matrix: random bursty modify/query traffic
// against an in-bench adjacency predictor. Depends on wgam_pkg and the top level RTL only.
`timescale 1ns / 1ps

module tb_weighted_graph_adjacency_matrix;

  typedef struct packed {
    logic                          op;
    logic [wgam_pkg::VTX_W-1:0]    a;
    logic [wgam_pkg::VTX_W-1:0]    b;
    logic [wgam_pkg::WEIGHT_W-1:0] w;
  } graph_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = wgam_pkg::OP_LIST;
  logic [wgam_pkg::VTX_W-1:0] in_vertex_a = '0;
  logic [wgam_pkg::VTX_W-1:0] in_vertex_b = '0;
  logic signed [wgam_pkg::WEIGHT_W-1:0] in_edge_weight = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [wgam_pkg::VTX_W-1:0] out_neighbor;
  logic signed [wgam_pkg::WEIGHT_W-1:0] out_neighbor_weight;
  logic out_last;

  graph_cmd_t pending_cmds[$];
  wgam_pkg::res_t expected_neighbors[$];
  logic link_present[0:15][0:15];
  logic [wgam_pkg::WEIGHT_W-1:0] link_weight[0:15][0:15];
  logic accepted = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int mismatches = 0;

  weighted_graph_adjacency_matrix dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_vertex_a         (in_vertex_a),
    .in_vertex_b         (in_vertex_b),
    .in_edge_weight      (in_edge_weight),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_neighbor        (out_neighbor),
    .out_neighbor_weight (out_neighbor_weight),
    .out_last            (out_last)
  );

  always #10 clk = ~clk;

  function automatic logic vertex_ok(input logic [wgam_pkg::VTX_W-1:0] v);
    return (v >= 1) && (v <= wgam_pkg::VERTICES);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic predict_adjacency(input graph_cmd_t cmd);
    int hits;
    wgam_pkg::res_t r;
    hits = 0;
    r = '{status: wgam_pkg::ST_INVALID, neighbor: '0, weight: '0, last: 1'b1};
    if (cmd.op == wgam_pkg::OP_MODIFY) begin
      if (!vertex_ok(cmd.a) || !vertex_ok(cmd.b)) begin
        expected_neighbors.push_back(r);
      end else begin
        link_present[cmd.a][cmd.b] = (cmd.w != '0);
        link_present[cmd.b][cmd.a] = (cmd.w != '0);
        link_weight[cmd.a][cmd.b] = cmd.w;
        link_weight[cmd.b][cmd.a] = cmd.w;
      end
    end else if (!vertex_ok(cmd.a)) begin
      expected_neighbors.push_back(r);
    end else begin
      for (int c = 1; c <= wgam_pkg::VERTICES; c++) begin
        if (link_present[cmd.a][c]) begin
          r.status = wgam_pkg::ST_NEIGHBOR;
          r.neighbor = wgam_pkg::VTX_W'(c);
          r.weight = link_weight[cmd.a][c];
          r.last = 1'b0;
          expected_neighbors.push_back(r);
          hits++;
        end
      end
      if (hits == 0) begin
        r.status = wgam_pkg::ST_NONE;
        expected_neighbors.push_back(r);
      end else begin
        r = expected_neighbors.pop_back();
        r.last = 1'b1;
        expected_neighbors.push_back(r);
      end
    end
  endtask

  task automatic add_cmd(input logic op, input int a, input int b, input logic [15:0] w);
    pending_cmds.push_back(graph_cmd_t'{op: op, a: wgam_pkg::VTX_W'(a),
                                        b: wgam_pkg::VTX_W'(b), w: w});
  endtask

  function automatic int pick_vertex(input logic valid_name);
    int v;
    if (valid_name) return $urandom_range(1, wgam_pkg::VERTICES);
    v = $urandom_range(0, 7);
    return (v == 0) ? 0 : v + 8;
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      predict_adjacency(graph_cmd_t'{op: in_operation, a: in_vertex_a, b: in_vertex_b,
                                     w: in_edge_weight});
  end

  always @(negedge clk) begin : drive_cmds
    graph_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !accepted) begin
      // hold until the transfer happens
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      cmd = pending_cmds.pop_front();
      in_operation <= cmd.op;
      in_vertex_a <= cmd.a;
      in_vertex_b <= cmd.b;
      in_edge_weight <= cmd.w;
      in_valid <= 1'b1;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_stall
    logic stall_next;
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase = $urandom_range(20, 80);
    end
    stall_phase--;
    case (stall_mode)
      0: stall_next = 1'b0;
      1: stall_next = 1'($urandom_range(0, 1));
      2: stall_next = ($urandom_range(0, 3) != 0);
      default: stall_next = ((stall_phase % 5) < 2);
    endcase
    out_stall <= stall_next;
  end

  always @(posedge clk) begin : check_results
    wgam_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_neighbors.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(out_status), 32'hx);
      end else begin
        want = expected_neighbors.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_neighbor !== want.neighbor)
          report_mismatch("neighbor", 32'(out_neighbor), 32'(want.neighbor));
        if (out_neighbor_weight !== want.weight)
          report_mismatch("weight", 32'(out_neighbor_weight), 32'(want.weight));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  initial begin
    for (int r = 0; r < 16; r++) begin
      for (int c = 0; c < 16; c++) begin
        link_present[r][c] = 1'b0;
        link_weight[r][c] = '0;
      end
    end

    // empty store and name extremes
    add_cmd(wgam_pkg::OP_LIST, 1, 15, 16'hffff);
    add_cmd(wgam_pkg::OP_LIST, 0, 0, 16'h0000);
    add_cmd(wgam_pkg::OP_LIST, 15, 3, 16'h1234);
    add_cmd(wgam_pkg::OP_MODIFY, 0, 3, 16'h0042);
    add_cmd(wgam_pkg::OP_MODIFY, 3, 9, 16'h0042);
    add_cmd(wgam_pkg::OP_MODIFY, 15, 15, 16'hffff);
    // self loops, weight extremes, overwrite and delete
    add_cmd(wgam_pkg::OP_MODIFY, 1, 1, 16'h7fff);
    add_cmd(wgam_pkg::OP_MODIFY, 1, 8, 16'h8000);
    add_cmd(wgam_pkg::OP_MODIFY, 8, 8, 16'hffff);
    add_cmd(wgam_pkg::OP_MODIFY, 1, 2, 16'h0001);
    add_cmd(wgam_pkg::OP_LIST, 1, 0, 16'h0000);
    add_cmd(wgam_pkg::OP_LIST, 8, 0, 16'h0000);
    add_cmd(wgam_pkg::OP_MODIFY, 2, 1, 16'haaaa);
    add_cmd(wgam_pkg::OP_MODIFY, 3, 4, 16'h0000);
    add_cmd(wgam_pkg::OP_MODIFY, 1, 2, 16'h0000);
    add_cmd(wgam_pkg::OP_LIST, 2, 0, 16'h0000);
    add_cmd(wgam_pkg::OP_LIST, 1, 0, 16'h0000);
    // full row
    for (int c = 1; c <= wgam_pkg::VERTICES; c++)
      add_cmd(wgam_pkg::OP_MODIFY, 5, c, 16'(c * 16'h1111 + 16'h0f00));
    add_cmd(wgam_pkg::OP_LIST, 5, 0, 16'h0000);

    for (int i = 0; i < 224; i++) begin
      case ($urandom_range(0, 19))
        0, 1:
          add_cmd(wgam_pkg::OP_MODIFY, pick_vertex(1'($urandom_range(0, 1))),
                  pick_vertex(1'b0), pick_weight());
        2:
          add_cmd(wgam_pkg::OP_LIST, pick_vertex(1'b0), $urandom_range(0, 15),
                  16'($urandom));
        3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
          add_cmd(wgam_pkg::OP_MODIFY, pick_vertex(1'b1), pick_vertex(1'b1),
                  pick_weight());
        default:
          add_cmd(wgam_pkg::OP_LIST, pick_vertex(1'b1), $urandom_range(0, 15),
                  16'($urandom));
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_weighted_graph_adjacency_matrix: PASS");
    end else begin
      $display("tb_weighted_graph_adjacency_matrix: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_weighted_graph_adjacency_matrix: FAIL");
    $finish;
  end

endmodule
